// ===== hw/rtl/mdfsr_pkg.sv =====
// Shared constants, op codes and state type for the mono display frame store.
// No dependencies; used by mono_display_frame_store_refresh and its testbench.
package mdfsr_pkg;

   localparam int COLUMNS    = 128;
   localparam int PAGES      = 8;
   localparam int STORE_SIZE = COLUMNS * PAGES;
   localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
   localparam int PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int HEAD_BYTES = 3;
   localparam int STEP_W     = $clog2(COLUMNS + HEAD_BYTES);
   localparam int ROWS       = 8 * PAGES;

   localparam logic [7:0] CMD_PAGE_BASE   = 8'hB0;
   localparam logic [7:0] CMD_COL_HIGH    = 8'h10;
   localparam logic [7:0] CMD_DISPLAY_ON  = 8'hAF;
   localparam logic [7:0] CMD_DISPLAY_OFF = 8'hAE;
   localparam logic [6:0] COLUMN_START_RESET = 7'd4;

   typedef enum logic [2:0] {
      OP_DRAW    = 3'd0,
      OP_CLEAR   = 3'd1,
      OP_REFRESH = 3'd2,
      OP_TICK    = 3'd3,
      OP_DISPLAY = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RMW   = 4'b0010,
      ST_TICK  = 4'b0100,
      ST_CLEAR = 4'b1000
   } state_type;

endpackage

// ===== hw/rtl/mono_display_frame_store_refresh.sv =====
// Frame store and refresh byte sequencer for a page-organized monochrome panel.
// Depends on mdfsr_pkg and mdfsr_ram.
//
// Usage: a transaction is taken when start is high and busy is low; req_op
// selects draw point, clear, start refresh, tick or display on/off. Each
// result appears for one cycle with rsp_strobe high; the receiver cannot
// stall, so results are never held back.
// Command results (page/column commands, display on/off) appear the cycle
// after the transaction, with busy staying low: one transaction per cycle.
// A draw point is a read-modify-write of one store byte, busy in the RMW
// state. A tick that sends a data byte reads the store via the registered
// RAM read port, holds busy in the TICK state, then registers the byte.
// Clear writes zero to the store one byte a cycle, busy until STORE_SIZE
// (1024) bytes are written, then a refresh starts from page 0. Reset runs
// the same clearing pass with busy high but starts no refresh; the csr_
// channel is always ready and column_start returns to 4.
module mono_display_frame_store_refresh (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_op,
   input  logic [7:0] req_x,
   input  logic [7:0] req_y,
   input  logic       req_pixel_on,
   output logic       rsp_strobe,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_data,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_column_start
);

   localparam int AW = mdfsr_pkg::ADDR_W;
   localparam int PW = mdfsr_pkg::PAGE_W;
   localparam int SW = mdfsr_pkg::STEP_W;

   mdfsr_pkg::state_type state_ff, state_in;
   logic          refresh_ff, refresh_in;
   logic [PW-1:0] page_ff, page_in;
   logic [SW-1:0] step_ff, step_in;
   logic [6:0]    col_start_ff;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [7:0]    mask_ff, mask_in;
   logic          on_ff, on_in;
   logic          last_ff, last_in;
   logic          strobe_ff, strobe_in;
   logic [7:0]    byte_ff, byte_in;
   logic          is_data_ff, is_data_in;
   logic          out_last_ff, out_last_in;

   logic          accept;
   logic [AW-1:0] draw_addr, data_addr, rd_addr, wr_addr;
   logic [7:0]    rd_data, wr_data;
   logic          wr_en;
   logic          draw_ok, end_page, end_all;
   logic [PW-1:0] draw_page;

   assign accept    = start && !busy;
   assign busy      = (state_ff != mdfsr_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   assign draw_ok   = (32'(req_x) < mdfsr_pkg::COLUMNS) && (32'(req_y) < mdfsr_pkg::ROWS);
   assign draw_page = PW'(mdfsr_pkg::PAGES - 1 - 32'(req_y[7:3]));
   assign draw_addr = AW'(AW'(req_x) * AW'(mdfsr_pkg::PAGES) + AW'(draw_page));
   assign data_addr = AW'(AW'(step_ff - SW'(mdfsr_pkg::HEAD_BYTES)) * AW'(mdfsr_pkg::PAGES)
                      + AW'(page_ff));
   assign end_page  = (step_ff == SW'(mdfsr_pkg::COLUMNS + mdfsr_pkg::HEAD_BYTES - 1));
   assign end_all   = end_page && (page_ff == PW'(mdfsr_pkg::PAGES - 1));

   assign rd_addr = (req_op == mdfsr_pkg::OP_TICK) ? data_addr : draw_addr;
   assign wr_en   = (state_ff == mdfsr_pkg::ST_RMW) || (state_ff == mdfsr_pkg::ST_CLEAR);
   assign wr_addr = (state_ff == mdfsr_pkg::ST_CLEAR) ? clr_addr_ff : addr_ff;
   assign wr_data = (state_ff == mdfsr_pkg::ST_CLEAR) ? 8'h00 :
                    (on_ff ? (rd_data | mask_ff) : (rd_data & ~mask_ff));

   mdfsr_ram #(
      .ADDR_W (AW),
      .DATA_W (8)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      refresh_in  = refresh_ff;
      page_in     = page_ff;
      step_in     = step_ff;
      clr_addr_in = clr_addr_ff;
      addr_in     = addr_ff;
      mask_in     = mask_ff;
      on_in       = on_ff;
      last_in     = last_ff;
      strobe_in   = 1'b0;
      byte_in     = byte_ff;
      is_data_in  = is_data_ff;
      out_last_in = out_last_ff;

      case (state_ff)
         mdfsr_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  mdfsr_pkg::OP_DRAW: begin
                     addr_in = draw_addr;
                     mask_in = 8'h80 >> req_y[2:0];
                     on_in   = req_pixel_on;
                     if (draw_ok) begin
                        state_in = mdfsr_pkg::ST_RMW;
                     end
                  end
                  mdfsr_pkg::OP_CLEAR: begin
                     clr_addr_in = '0;
                     refresh_in  = 1'b1;
                     page_in     = '0;
                     step_in     = '0;
                     state_in    = mdfsr_pkg::ST_CLEAR;
                  end
                  mdfsr_pkg::OP_REFRESH: begin
                     refresh_in = 1'b1;
                     page_in    = '0;
                     step_in    = '0;
                  end
                  mdfsr_pkg::OP_TICK: begin
                     if (refresh_ff) begin
                        if (step_ff == SW'(0)) begin
                           strobe_in   = 1'b1;
                           byte_in     = 8'(mdfsr_pkg::CMD_PAGE_BASE + 8'(page_ff));
                           is_data_in  = 1'b0;
                           out_last_in = 1'b0;
                           step_in     = step_ff + SW'(1);
                        end else if (step_ff == SW'(1)) begin
                           strobe_in   = 1'b1;
                           byte_in     = mdfsr_pkg::CMD_COL_HIGH | {5'd0, col_start_ff[6:4]};
                           is_data_in  = 1'b0;
                           out_last_in = 1'b0;
                           step_in     = step_ff + SW'(1);
                        end else if (step_ff == SW'(2)) begin
                           strobe_in   = 1'b1;
                           byte_in     = {4'd0, col_start_ff[3:0]};
                           is_data_in  = 1'b0;
                           out_last_in = 1'b0;
                           step_in     = step_ff + SW'(1);
                        end else begin
                           last_in  = end_all;
                           state_in = mdfsr_pkg::ST_TICK;
                           if (end_page) begin
                              step_in = '0;
                              if (end_all) begin
                                 refresh_in = 1'b0;
                                 page_in    = '0;
                              end else begin
                                 page_in = page_ff + PW'(1);
                              end
                           end else begin
                              step_in = step_ff + SW'(1);
                           end
                        end
                     end
                  end
                  mdfsr_pkg::OP_DISPLAY: begin
                     if (!refresh_ff) begin
                        strobe_in   = 1'b1;
                        byte_in     = req_pixel_on ? mdfsr_pkg::CMD_DISPLAY_ON
                                                   : mdfsr_pkg::CMD_DISPLAY_OFF;
                        is_data_in  = 1'b0;
                        out_last_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         mdfsr_pkg::ST_RMW: begin
            state_in = mdfsr_pkg::ST_IDLE;
         end
         mdfsr_pkg::ST_TICK: begin
            strobe_in   = 1'b1;
            byte_in     = rd_data;
            is_data_in  = 1'b1;
            out_last_in = last_ff;
            state_in    = mdfsr_pkg::ST_IDLE;
         end
         mdfsr_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(mdfsr_pkg::STORE_SIZE - 1)) begin
               state_in = mdfsr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mdfsr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mdfsr_pkg::ST_CLEAR;
         refresh_ff   <= 1'b0;
         page_ff      <= '0;
         step_ff      <= '0;
         clr_addr_ff  <= '0;
         strobe_ff    <= 1'b0;
         col_start_ff <= mdfsr_pkg::COLUMN_START_RESET;
      end else begin
         state_ff    <= state_in;
         refresh_ff  <= refresh_in;
         page_ff     <= page_in;
         step_ff     <= step_in;
         clr_addr_ff <= clr_addr_in;
         strobe_ff   <= strobe_in;
         if (csr_valid && csr_ready) begin
            col_start_ff <= csr_column_start;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      mask_ff     <= mask_in;
      on_ff       <= on_in;
      last_ff     <= last_in;
      byte_ff     <= byte_in;
      is_data_ff  <= is_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_is_data  = is_data_ff;
   assign rsp_last     = out_last_ff;

endmodule

// ===== hw/rtl/mdfsr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mdfsr_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== verif/frame_refresh_checker.sv =====
// Predicts the panel byte stream of mono_display_frame_store_refresh and compares it
// with the rsp_ channel. Depends on mdfsr_pkg; instantiated by the testbench top.
module frame_refresh_checker
   import mdfsr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic [2:0] req_op,
   input  logic [7:0] req_x,
   input  logic [7:0] req_y,
   input  logic       req_pixel_on,
   input  logic       rsp_strobe,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_is_data,
   input  logic       rsp_last,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [6:0] csr_column_start,
   output int         mismatch_count,
   output int         bytes_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] value;
      logic       is_data;
      logic       last;
   } panel_byte_t;

   logic [7:0]        frame_mem [STORE_SIZE];
   logic              scan_active;
   logic [PAGE_W-1:0] scan_page;
   logic [STEP_W-1:0] scan_step;
   logic [6:0]        col_origin;
   panel_byte_t       expected_bytes [$];
   int                errors;

   task automatic queue_byte(input logic [7:0] value, input logic is_data, input logic last);
      panel_byte_t entry;
      entry.value   = value;
      entry.is_data = is_data;
      entry.last    = last;
      expected_bytes.push_back(entry);
   endtask

   task automatic begin_scan();
      scan_active = 1'b1;
      scan_page   = '0;
      scan_step   = '0;
   endtask

   task automatic plot_pixel(input logic [7:0] x, input logic [7:0] y, input logic on);
      int         page;
      int         addr;
      logic [7:0] mask;
      if (x > COLUMNS - 1 || y > ROWS - 1)
         return;
      page = PAGES - 1 - y / 8;
      mask = 8'h80 >> y[2:0];
      addr = x * PAGES + page;
      frame_mem[addr] = on ? (frame_mem[addr] | mask) : (frame_mem[addr] & ~mask);
   endtask

   task automatic advance_scan();
      int   col;
      logic end_page;
      logic end_all;
      if (!scan_active)
         return;
      if (scan_step == 0) begin
         queue_byte(CMD_PAGE_BASE + scan_page, 1'b0, 1'b0);
      end else if (scan_step == 1) begin
         queue_byte(CMD_COL_HIGH | {5'd0, col_origin[6:4]}, 1'b0, 1'b0);
      end else if (scan_step == 2) begin
         queue_byte({4'd0, col_origin[3:0]}, 1'b0, 1'b0);
      end else begin
         col      = scan_step - HEAD_BYTES;
         end_page = (col == COLUMNS - 1);
         end_all  = end_page && (scan_page == PAGES - 1);
         queue_byte(frame_mem[col * PAGES + scan_page], 1'b1, end_all);
         if (end_page) begin
            scan_step = '0;
            if (end_all) begin
               scan_active = 1'b0;
               scan_page   = '0;
            end else begin
               scan_page = scan_page + 1'b1;
            end
            return;
         end
      end
      scan_step = scan_step + 1'b1;
   endtask

   task automatic check_panel_byte();
      panel_byte_t want;
      if (expected_bytes.size() == 0) begin
         $display("%0t: unexpected panel byte: expected none, actual %02h is_data=%0b last=%0b",
                  $time, rsp_out_byte, rsp_is_data, rsp_last);
         errors++;
         return;
      end
      want = expected_bytes.pop_front();
      if ({rsp_out_byte, rsp_is_data, rsp_last} !== want) begin
         $display("%0t: panel byte mismatch: expected %02h/%0b/%0b, actual %02h/%0b/%0b",
                  $time, want.value, want.is_data, want.last,
                  rsp_out_byte, rsp_is_data, rsp_last);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (frame_mem[i])
            frame_mem[i] = '0;
         scan_active = 1'b0;
         scan_page   = '0;
         scan_step   = '0;
         col_origin  = COLUMN_START_RESET;
         expected_bytes.delete();
         errors      = 0;
      end else begin
         if (rsp_strobe)
            check_panel_byte();
         if (csr_valid && csr_ready)
            col_origin = csr_column_start;
         if (start && !busy) begin
            case (req_op)
               OP_DRAW: plot_pixel(req_x, req_y, req_pixel_on);
               OP_CLEAR: begin
                  foreach (frame_mem[i])
                     frame_mem[i] = '0;
                  begin_scan();
               end
               OP_REFRESH: begin_scan();
               OP_TICK: advance_scan();
               OP_DISPLAY: begin
                  if (!scan_active)
                     queue_byte(req_pixel_on ? CMD_DISPLAY_ON : CMD_DISPLAY_OFF, 1'b0, 1'b0);
               end
               default: ;
            endcase
         end
      end
      mismatch_count    <= errors;
      bytes_outstanding <= expected_bytes.size();
   end

endmodule

// ===== verif/mono_display_frame_store_refresh_tb.sv =====
// Testbench top for mono_display_frame_store_refresh: clock, reset, stimulus and verdict.
// Depends on mdfsr_pkg, the block itself and frame_refresh_checker.
module mono_display_frame_store_refresh_tb
   import mdfsr_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
   localparam int GAP_MAX        = 18;
   localparam int TARGET_ITEMS   = 1650;
   localparam int SCAN_ITEM_CAP  = 1600;
   localparam int WATCHDOG_LIMIT = 8000;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [2:0] req_op;
   logic [7:0] req_x;
   logic [7:0] req_y;
   logic       req_pixel_on;
   logic       rsp_strobe;
   logic [7:0] rsp_out_byte;
   logic       rsp_is_data;
   logic       rsp_last;
   logic       csr_valid;
   logic       csr_ready;
   logic [6:0] csr_column_start;

   int mismatch_count;
   int bytes_outstanding;
   int items_sent;
   int bytes_seen = 0;
   int frame_ends = 0;
   int origin_writes;
   int quiet_cycles = 0;
   bit no_idle;

   mono_display_frame_store_refresh dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_x            (req_x),
      .req_y            (req_y),
      .req_pixel_on     (req_pixel_on),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_data      (rsp_is_data),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_column_start (csr_column_start)
   );

   frame_refresh_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_x             (req_x),
      .req_y             (req_y),
      .req_pixel_on      (req_pixel_on),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_is_data       (rsp_is_data),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_column_start  (csr_column_start),
      .mismatch_count    (mismatch_count),
      .bytes_outstanding (bytes_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (rsp_strobe) begin
         bytes_seen <= bytes_seen + 1;
         if (rsp_last)
            frame_ends <= frame_ends + 1;
      end
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("mono_display_frame_store_refresh_tb: FAIL");
         $finish;
      end
   end

   task automatic send_item(input logic [2:0] op, input logic [7:0] x, input logic [7:0] y,
                            input logic on);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start        <= 1'b1;
      req_op       <= op;
      req_x        <= x;
      req_y        <= y;
      req_pixel_on <= on;
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
      items_sent++;
   endtask

   task automatic send_random(input bit scan_heavy);
      int         pick;
      logic [2:0] op;
      logic [7:0] x;
      logic [7:0] y;
      logic       on;
      pick = $urandom_range(0, 99);
      x    = 8'($urandom_range(0, 255));
      y    = 8'($urandom_range(0, 255));
      on   = 1'($urandom_range(0, 1));
      if (scan_heavy) begin
         if (pick < 85)
            op = OP_TICK;
         else if (pick < 97)
            op = OP_DRAW;
         else if (pick < 99)
            op = OP_DISPLAY;
         else
            op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      end else begin
         if (pick < 30)
            op = OP_DRAW;
         else if (pick < 65)
            op = OP_TICK;
         else if (pick < 75)
            op = OP_REFRESH;
         else if (pick < 87)
            op = OP_DISPLAY;
         else if (pick < 89)
            op = OP_CLEAR;
         else
            op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      end
      if (op == OP_DRAW) begin
         x = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                         : 8'($urandom_range(0, 127));
         y = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(64, 255))
                                         : 8'($urandom_range(0, 63));
      end
      if ($urandom_range(0, 49) == 0)
         no_idle = !no_idle;
      send_item(op, x, y, on);
   endtask

   // hold start low, drain expected bytes, then let the block go idle
   task automatic drain_and_idle();
      @(negedge clock);
      start <= 1'b0;
      forever begin
         @(posedge clock);
         if (bytes_outstanding == 0)
            break;
      end
      repeat (4) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_column_start(input logic [6:0] value);
      @(negedge clock);
      csr_valid        <= 1'b1;
      csr_column_start <= value;
      forever begin
         @(posedge clock);
         if (csr_ready)
            break;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      origin_writes++;
   endtask

   initial begin
      int ends_before;
      int scan_items;
      reset            = 1'b1;
      start            = 1'b0;
      req_op           = OP_DRAW;
      req_x            = '0;
      req_y            = '0;
      req_pixel_on     = 1'b0;
      csr_valid        = 1'b0;
      csr_column_start = '0;
      items_sent       = 0;
      origin_writes    = 0;
      no_idle          = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(OP_DISPLAY, 8'd0, 8'd0, 1'b1);
      send_item(OP_DISPLAY, 8'd255, 8'd255, 1'b0);
      send_item(OP_TICK, 8'd0, 8'd0, 1'b0);
      send_item(OP_DRAW, 8'd0, 8'd0, 1'b1);
      send_item(OP_DRAW, 8'd127, 8'd63, 1'b1);
      send_item(OP_DRAW, 8'd127, 8'd0, 1'b1);
      send_item(OP_DRAW, 8'd0, 8'd63, 1'b1);
      send_item(OP_DRAW, 8'd128, 8'd0, 1'b1);
      send_item(OP_DRAW, 8'd0, 8'd64, 1'b1);
      send_item(OP_DRAW, 8'd255, 8'd255, 1'b1);
      send_item(OP_DRAW, 8'd127, 8'd63, 1'b0);
      send_item(OP_SPARE_FIRST, 8'd255, 8'd255, 1'b1);
      send_item(OP_SPARE_LAST, 8'd255, 8'd255, 1'b1);
      send_item(OP_REFRESH, 8'd0, 8'd0, 1'b0);
      repeat (5) send_item(OP_TICK, 8'd0, 8'd0, 1'b0);
      send_item(OP_DISPLAY, 8'd0, 8'd0, 1'b1);
      send_item(OP_REFRESH, 8'd0, 8'd0, 1'b0);
      send_item(OP_TICK, 8'd0, 8'd0, 1'b0);
      send_item(OP_CLEAR, 8'd0, 8'd0, 1'b0);
      send_item(OP_TICK, 8'd0, 8'd0, 1'b0);
      send_item(OP_DISPLAY, 8'd0, 8'd0, 1'b0);
      drain_and_idle();

      write_column_start(7'd127);
      repeat (150) send_random(1'b0);
      drain_and_idle();

      write_column_start(7'd0);
      send_item(OP_REFRESH, 8'd0, 8'd0, 1'b0);
      ends_before = frame_ends;
      scan_items  = 0;
      while (frame_ends == ends_before && scan_items < SCAN_ITEM_CAP) begin
         send_random(1'b1);
         scan_items++;
      end

      while (items_sent < TARGET_ITEMS) begin
         drain_and_idle();
         write_column_start(7'($urandom_range(0, 127)));
         repeat (80) send_random(1'b0);
      end
      drain_and_idle();

      $display("covered %0d transactions, %0d panel bytes, %0d full refreshes,",
               items_sent, bytes_seen, frame_ends);
      $display("and %0d column_start writes including both extremes", origin_writes);
      if (mismatch_count == 0 && bytes_outstanding == 0) begin
         $display("mono_display_frame_store_refresh_tb: PASS");
      end else begin
         $display("mono_display_frame_store_refresh_tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/mdfsr_pkg.sv
hw/rtl/mdfsr_ram.sv
hw/rtl/mono_display_frame_store_refresh.sv
verif/frame_refresh_checker.sv
verif/mono_display_frame_store_refresh_tb.sv
